/* src/ws2812_pixel_pulse_encoder_defines.svh */
// assertion macros for the ws2812 pixel pulse encoder
// used by the top level, expects clk and rst in scope
`ifndef WS2812_PIXEL_PULSE_ENCODER_DEFINES_SVH
`define WS2812_PIXEL_PULSE_ENCODER_DEFINES_SVH

// same-cycle implication
`define WSPPE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WSPPE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/wsppe_pkg.sv */
// shared types, constants and gamma table for the ws2812 pixel pulse encoder
// no dependencies
package wsppe_pkg;

  localparam int DUTY_BITS_DEF  = 16;
  localparam int FIELD_BITS     = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int PIX_BITS       = 24;
  localparam int CNT_BITS       = $clog2(PIX_BITS);
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_DUTY  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_DUTY   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAMMA_MODE = 2'd2;

  localparam logic [1:0] GAMMA_NONE  = 2'd0;
  localparam logic [1:0] GAMMA_TABLE = 2'd1;
  localparam logic [1:0] GAMMA_QUAD  = 2'd2;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_BLANK = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] duty;
    logic                  last_of_run;
  } result_t;

  typedef struct packed {
    logic                blank;
    logic [PIX_BITS-1:0] bits;
  } word_t;

  typedef struct packed {
    logic                busy;
    logic [CNT_BITS-1:0] cnt;
  } back_status_t;

  localparam logic [7:0] GAMMA_LUT [256] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1,
    8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd3, 8'd3, 8'd3, 8'd3, 8'd4, 8'd4, 8'd4, 8'd4,
    8'd5, 8'd5, 8'd5, 8'd5, 8'd6, 8'd6, 8'd6, 8'd7, 8'd7, 8'd7, 8'd8, 8'd8, 8'd8, 8'd9,
    8'd9, 8'd9, 8'd10,
    8'd10, 8'd11, 8'd11, 8'd11, 8'd12, 8'd12, 8'd13, 8'd13, 8'd14, 8'd14, 8'd15, 8'd15,
    8'd16, 8'd16, 8'd17, 8'd17, 8'd18, 8'd18, 8'd19, 8'd19, 8'd20, 8'd20, 8'd21, 8'd21,
    8'd22, 8'd23, 8'd23, 8'd24, 8'd24, 8'd25, 8'd26, 8'd26, 8'd27, 8'd28, 8'd28, 8'd29,
    8'd30, 8'd30, 8'd31, 8'd32, 8'd32, 8'd33, 8'd34, 8'd35, 8'd35, 8'd36, 8'd37, 8'd38,
    8'd38, 8'd39, 8'd40, 8'd41, 8'd42, 8'd42, 8'd43, 8'd44, 8'd45, 8'd46, 8'd47, 8'd47,
    8'd48, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56, 8'd56, 8'd57, 8'd58,
    8'd59, 8'd60, 8'd61, 8'd62, 8'd63, 8'd64, 8'd65, 8'd66, 8'd67, 8'd68, 8'd69, 8'd70,
    8'd71, 8'd73, 8'd74, 8'd75, 8'd76, 8'd77, 8'd78, 8'd79, 8'd80, 8'd81, 8'd82, 8'd84,
    8'd85, 8'd86, 8'd87, 8'd88, 8'd89, 8'd91, 8'd92, 8'd93, 8'd94, 8'd95, 8'd97, 8'd98,
    8'd99, 8'd100, 8'd102, 8'd103, 8'd104, 8'd105, 8'd107, 8'd108, 8'd109, 8'd111,
    8'd112, 8'd113, 8'd115, 8'd116, 8'd117, 8'd119, 8'd120, 8'd121, 8'd123, 8'd124,
    8'd126, 8'd127, 8'd128, 8'd130, 8'd131, 8'd133, 8'd134, 8'd136, 8'd137,
    8'd139, 8'd140, 8'd142, 8'd143, 8'd145, 8'd146, 8'd148, 8'd149, 8'd151, 8'd152,
    8'd154, 8'd155, 8'd157, 8'd158, 8'd160, 8'd162, 8'd163, 8'd165, 8'd166,
    8'd168, 8'd170, 8'd171, 8'd173, 8'd175, 8'd176, 8'd178, 8'd180, 8'd181, 8'd183,
    8'd185, 8'd186, 8'd188, 8'd190, 8'd192, 8'd193, 8'd195, 8'd197, 8'd199,
    8'd200, 8'd202, 8'd204, 8'd206, 8'd207, 8'd209, 8'd211, 8'd213, 8'd215, 8'd217,
    8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232, 8'd233,
    8'd235, 8'd237, 8'd239, 8'd241, 8'd243, 8'd245, 8'd247, 8'd249, 8'd251, 8'd253, 8'd255
  };

endpackage

/* src/wsppe_front.sv */
// front end: gamma correction and packing of one item into a 24-bit word
// depends on wsppe_pkg
module wsppe_front (
  input  wsppe_pkg::item_t item,
  input  logic [1:0]       gamma_mode,
  output wsppe_pkg::word_t word
);
  import wsppe_pkg::*;

  function automatic logic [7:0] correct(input logic [7:0] v, input logic [1:0] mode);
    logic [15:0] sq;
    logic [15:0] sum;
    sq  = 16'(v) * 16'(v);
    sum = sq + 16'(v);
    case (mode)
      GAMMA_TABLE: correct = GAMMA_LUT[v];
      GAMMA_QUAD:  correct = sum[15:8];
      default:     correct = v;
    endcase
  endfunction

  // green, red, blue, msb first
  always_comb begin
    word.blank = (item.kind == KIND_BLANK);
    word.bits  = {correct(item.green, gamma_mode),
                  correct(item.red, gamma_mode),
                  correct(item.blue, gamma_mode)};
  end

endmodule

/* src/wsppe_queue.sv */
// short queue of packed words between front and back
// depends on wsppe_pkg
module wsppe_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  wsppe_pkg::word_t wr_data,
  output logic             full,
  input  logic             rd,
  output wsppe_pkg::word_t rd_data,
  output logic             empty
);
  import wsppe_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);

  word_t               slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                do_wr;
  logic                do_rd;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

/* src/wsppe_back.sv */
// back end: shifts a word out one bit per cycle as timer compare values
// while the output is not held unpopped; depends on wsppe_pkg
module wsppe_back #(
  parameter int DUTY_BITS = wsppe_pkg::DUTY_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [DUTY_BITS-1:0]    high_duty,
  input  logic [DUTY_BITS-1:0]    low_duty,
  input  wsppe_pkg::word_t        q_data,
  input  logic                    q_empty,
  output logic                    q_pop,
  output wsppe_pkg::result_t      result,
  output logic                    empty,
  input  logic                    pop,
  output wsppe_pkg::back_status_t status
);
  import wsppe_pkg::*;

  localparam logic [CNT_BITS-1:0] LAST_CNT = CNT_BITS'(PIX_BITS - 1);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [PIX_BITS-1:0] shift;
  logic                blank;
  logic                out_vld;
  result_t             out_q;
  logic                advance;
  logic                finish;
  logic [DUTY_BITS-1:0] duty_next;

  assign advance   = busy && (!out_vld || pop);
  assign finish    = advance && (cnt == LAST_CNT);
  assign q_pop     = !q_empty && (!busy || finish);
  assign duty_next = blank ? '0 : (shift[PIX_BITS-1] ? high_duty : low_duty);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      cnt     <= '0;
      out_vld <= 1'b0;
    end else begin
      if (advance) begin
        out_vld <= 1'b1;
      end else if (pop) begin
        out_vld <= 1'b0;
      end
      if (q_pop) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (finish) begin
        busy <= 1'b0;
        cnt  <= '0;
      end else if (advance) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      shift <= q_data.bits;
      blank <= q_data.blank;
    end else if (advance) begin
      shift <= {shift[PIX_BITS-2:0], 1'b0};
    end
    if (advance) begin
      out_q.duty        <= FIELD_BITS'(duty_next);
      out_q.last_of_run <= (cnt == LAST_CNT);
    end
  end

  assign result      = out_q;
  assign empty       = !out_vld;
  assign status.busy = busy;
  assign status.cnt  = cnt;

endmodule

/* src/ws2812_pixel_pulse_encoder.sv */
// top level of the ws2812 pixel pulse encoder: config registers, front, queue, back
// depends on wsppe_pkg, wsppe_front, wsppe_queue, wsppe_back and the defines header
// Each pixel or blank item becomes 24 timer compare values, green, red, blue, msb
// first, with last_of_run set on the 24th. One value leaves per cycle from the back
// serializer unless the output is held, and the next queued item loads as the last
// one finishes, so that serializer sets the rate. The front applies gamma and writes
// a two-entry queue in the cycle an item is taken, so up to two items wait behind
// the one being shifted out. An item's first value passes the queue, the shift
// register and the output register, if the back end is idle and the output is free.
// Config is written through cfg_valid/cfg_ready, which is always ready, and should
// change only while the block is idle.
`include "ws2812_pixel_pulse_encoder_defines.svh"

module ws2812_pixel_pulse_encoder #(
  parameter int DUTY_BITS = wsppe_pkg::DUTY_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  wsppe_pkg::item_t                     item,
  output logic                                 empty,
  input  logic                                 pop,
  output wsppe_pkg::result_t                   result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wsppe_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [wsppe_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import wsppe_pkg::*;

  logic [DUTY_BITS-1:0] high_duty;
  logic [DUTY_BITS-1:0] low_duty;
  logic [1:0]           gamma_mode;
  word_t                front_word;
  word_t                q_data;
  logic                 q_empty;
  logic                 q_pop;
  back_status_t         status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_duty  <= DUTY_BITS'(58);
      low_duty   <= DUTY_BITS'(29);
      gamma_mode <= GAMMA_NONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HIGH_DUTY:  high_duty  <= cfg_data[DUTY_BITS-1:0];
        REG_LOW_DUTY:   low_duty   <= cfg_data[DUTY_BITS-1:0];
        REG_GAMMA_MODE: gamma_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  wsppe_front u_front (
    .item       (item),
    .gamma_mode (gamma_mode),
    .word       (front_word)
  );

  wsppe_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (push),
    .wr_data (front_word),
    .full    (full),
    .rd      (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  wsppe_back #(
    .DUTY_BITS (DUTY_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .high_duty (high_duty),
    .low_duty  (low_duty),
    .q_data    (q_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop),
    .status    (status)
  );

  // waiting word gets picked up by an idle back end
  `WSPPE_ASSERT_NXT(a_load_when_idle, !status.busy && !q_empty, status.busy, "queued word skipped")
  // bit counter only moves inside a run
  `WSPPE_ASSERT_IMP(a_cnt_in_run, status.cnt != '0, status.busy, "bit counter set while idle")
  // a full queue always has a word to read
  `WSPPE_ASSERT_IMP(a_full_not_empty, full, !q_empty, "queue full and empty at once")

endmodule
